[hdl/bnc_pkg.sv]
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types and constants of the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

  localparam int unsigned MAX_NESTING_DEF = 1024;

  localparam int unsigned LINE_W = 24;
  localparam int unsigned COL_W  = 16;

  localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
  localparam logic [COL_W-1:0]  COL_MAX  = {COL_W{1'b1}};

  localparam logic [7:0] CHR_NUL    = 8'h00;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_NL     = 8'h0A;
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_LBRACK = 8'h5B;
  localparam logic [7:0] CHR_RBRACK = 8'h5D;

  localparam logic [4:0] TAB_WIDTH_RST = 5'd8;

  // Register index, taken from paddr[2].
  localparam logic REG_TAB_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_DEEP  = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_UNCLOSED  = 3'd4
  } status_e;

  // One stack entry: bracket kind (1 for square) and its position.
  typedef struct packed {
    logic              square;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } bnc_entry_t;

  // A word as it leaves the front stage for evaluation.
  typedef struct packed {
    logic              last;
    logic [7:0]        text_byte;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              too_deep;
    logic              unmatched;
    logic              push;
    logic              pop;
    logic              want_square;
    logic              depth_nz;
  } bnc_item_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        bracket_byte;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } bnc_result_t;

  function automatic logic [7:0] opener_byte(input logic square);
    return square ? CHR_LBRACK : CHR_LPAREN;
  endfunction

endpackage

[hdl/bnc_ram.sv]
// ----------------------------------------------------------------------------
// bnc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bnc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hdl/bnc_front.sv]
// ----------------------------------------------------------------------------
// bnc_front
// Position tracking, stack depth and stack memory access for each word.
// ----------------------------------------------------------------------------
module bnc_front #(
  parameter int unsigned MaxNesting = 1024,
  localparam int unsigned AW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1,
  localparam int unsigned DW = $clog2(MaxNesting + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          tab_width_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                is_last_i,
  input  logic                advance_i,
  output logic                item_valid_o,
  output bnc_pkg::bnc_item_t  item_o,
  output logic                ram_we_o,
  output logic [AW-1:0]       ram_waddr_o,
  output bnc_pkg::bnc_entry_t ram_wdata_o,
  output logic                ram_re_o,
  output logic [AW-1:0]       ram_raddr_a_o,
  output logic [AW-1:0]       ram_raddr_b_o
);
  import bnc_pkg::*;

  logic [DW-1:0]     depth_q, depth_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              nul_q, nul_d;
  logic              valid_q, valid_d;
  bnc_item_t         item_q, item_d;

  logic              accept;
  logic [LINE_W-1:0] line_n;
  logic [COL_W-1:0]  col_n;
  logic              nul_n;
  logic [COL_W:0]    col_sum;
  logic [4:0]        col_inc;
  logic              is_open, is_close, too_deep, unmatched, push, pop;
  logic [DW-1:0]     depth_n, depth_m1, depth_m2;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  // Position after this byte; frozen once a NUL has been seen.
  always_comb begin
    line_n  = line_q;
    col_n   = col_q;
    nul_n   = nul_q;
    col_inc = (text_byte_i == CHR_TAB) ? tab_width_i : 5'd1;
    col_sum = {1'b0, col_q} + {{(COL_W - 4){1'b0}}, col_inc};
    if (!nul_q) begin
      if (text_byte_i == CHR_NUL) begin
        nul_n = 1'b1;
      end else if (text_byte_i == CHR_NL) begin
        if (line_q != LINE_MAX) begin
          line_n = line_q + LINE_W'(1);
        end
        col_n = '0;
      end else begin
        col_n = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
      end
    end
  end

  assign is_open   = (text_byte_i == CHR_LPAREN) || (text_byte_i == CHR_LBRACK);
  assign is_close  = (text_byte_i == CHR_RPAREN) || (text_byte_i == CHR_RBRACK);
  assign too_deep  = is_open && (depth_q >= DW'(MaxNesting));
  assign unmatched = is_close && (depth_q == '0);
  assign push      = is_open && !too_deep;
  assign pop       = is_close && !unmatched;
  assign depth_m1  = depth_q - DW'(1);
  assign depth_m2  = depth_q - DW'(2);

  always_comb begin
    depth_n = depth_q;
    if (push) begin
      depth_n = depth_q + DW'(1);
    end else if (pop) begin
      depth_n = depth_m1;
    end
  end

  // Port A reads the top entry, port B the one below it.
  assign ram_we_o           = accept && push;
  assign ram_waddr_o        = depth_q[AW-1:0];
  assign ram_wdata_o.square = (text_byte_i == CHR_LBRACK);
  assign ram_wdata_o.line   = line_n;
  assign ram_wdata_o.col    = col_n;
  assign ram_re_o           = accept;
  assign ram_raddr_a_o      = depth_m1[AW-1:0];
  assign ram_raddr_b_o      = depth_m2[AW-1:0];

  always_comb begin
    depth_d = depth_q;
    line_d  = line_q;
    col_d   = col_q;
    nul_d   = nul_q;
    item_d  = item_q;
    valid_d = advance_i ? 1'b0 : valid_q;
    if (accept) begin
      valid_d            = 1'b1;
      item_d.last        = is_last_i;
      item_d.text_byte   = text_byte_i;
      item_d.line        = line_n;
      item_d.col         = col_n;
      item_d.too_deep    = too_deep;
      item_d.unmatched   = unmatched;
      item_d.push        = push;
      item_d.pop         = pop;
      item_d.want_square = (text_byte_i == CHR_RBRACK);
      item_d.depth_nz    = (depth_n != '0);
      if (is_last_i) begin
        depth_d = '0;
        line_d  = LINE_W'(1);
        col_d   = '0;
        nul_d   = 1'b0;
      end else begin
        depth_d = depth_n;
        line_d  = line_n;
        col_d   = col_n;
        nul_d   = nul_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      line_q  <= LINE_W'(1);
      col_q   <= '0;
      nul_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      line_q  <= line_d;
      col_q   <= col_d;
      nul_q   <= nul_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hdl/bnc_back.sv]
// ----------------------------------------------------------------------------
// bnc_back
// Kind check against the stack data, result selection and output register.
// ----------------------------------------------------------------------------
module bnc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  bnc_pkg::bnc_item_t   item_i,
  input  bnc_pkg::bnc_entry_t  top_i,
  input  bnc_pkg::bnc_entry_t  below_i,
  output logic                 advance_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bnc_pkg::bnc_result_t result_o
);
  import bnc_pkg::*;

  logic        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  bnc_result_t result_q, result_d, res;
  bnc_entry_t  open_entry;
  logic        mismatch, err, emit;

  assign mismatch = item_i.pop && (top_i.square != item_i.want_square);
  assign err      = item_i.too_deep || item_i.unmatched || mismatch;
  // Words after an error are dropped until the end of the stream.
  assign emit     = !err_q && (err || item_i.last);

  assign advance_o = item_valid_i && (!emit || !out_valid_q || out_ready_i);

  // Innermost opener still open once this word is done.
  always_comb begin
    if (item_i.push) begin
      open_entry.square = (item_i.text_byte == CHR_LBRACK);
      open_entry.line   = item_i.line;
      open_entry.col    = item_i.col;
    end else if (item_i.pop) begin
      open_entry = below_i;
    end else begin
      open_entry = top_i;
    end
  end

  always_comb begin
    res.status       = ST_OK;
    res.bracket_byte = item_i.text_byte;
    res.line         = item_i.line;
    res.col          = item_i.col;
    if (item_i.too_deep) begin
      res.status = ST_TOO_DEEP;
    end else if (item_i.unmatched) begin
      res.status = ST_UNMATCHED;
    end else if (mismatch) begin
      res.status       = ST_MISMATCH;
      res.bracket_byte = opener_byte(top_i.square);
      res.line         = top_i.line;
      res.col          = top_i.col;
    end else if (item_i.depth_nz) begin
      res.status       = ST_UNCLOSED;
      res.bracket_byte = opener_byte(open_entry.square);
      res.line         = open_entry.line;
      res.col          = open_entry.col;
    end else begin
      res.bracket_byte = CHR_NUL;
    end
  end

  always_comb begin
    err_d       = err_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance_o) begin
      if (item_i.last) begin
        err_d = 1'b0;
      end else if (err) begin
        err_d = 1'b1;
      end
      if (emit) begin
        out_valid_d = 1'b1;
        result_d    = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[hdl/bracket_nesting_checker_top.sv]
// ----------------------------------------------------------------------------
// bracket_nesting_checker_top
// Checks round and square bracket nesting in a byte stream, with positions.
// ----------------------------------------------------------------------------
// The checker takes one text word per clock cycle, back to back, and a result
// leaves the output register after its word leaves the front stage. Open
// brackets live in a single stack memory, written at most once and read at
// two addresses per word; that memory pass sets the rate of one word per
// cycle. A word stalls only while a result waits at the output and the next
// result is already due. No clearing pass follows reset: a stack entry is
// always written within a stream before it is read. The tab width register
// sits at address 0 and should be written only while the checker is idle.
module bracket_nesting_checker_top #(
  parameter int unsigned MaxNesting = bnc_pkg::MAX_NESTING_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  bracket_byte_o,
  output logic [23:0] line_number_o,
  output logic [15:0] column_number_o
);
  import bnc_pkg::*;

  localparam int unsigned AW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;

  logic [4:0]  tab_width_q, tab_width_d;
  logic        item_valid, advance;
  bnc_item_t   item;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  bnc_entry_t  ram_wdata, top_entry, below_entry;
  bnc_result_t result;

  assign pready = 1'b1;

  always_comb begin
    tab_width_d = tab_width_q;
    if (psel && penable && pwrite && (paddr[2] == REG_TAB_WIDTH)) begin
      tab_width_d = pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_TAB_WIDTH) ? {27'd0, tab_width_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= TAB_WIDTH_RST;
    end else begin
      tab_width_q <= tab_width_d;
    end
  end

  bnc_front #(
    .MaxNesting(MaxNesting)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tab_width_i  (tab_width_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .is_last_i    (is_last_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_a_o(ram_raddr_a),
    .ram_raddr_b_o(ram_raddr_b)
  );

  bnc_ram #(
    .Width($bits(bnc_entry_t)),
    .Depth(MaxNesting)
  ) u_stack (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .re_i     (ram_re),
    .raddr_a_i(ram_raddr_a),
    .raddr_b_i(ram_raddr_b),
    .rdata_a_o(top_entry),
    .rdata_b_o(below_entry)
  );

  bnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .top_i       (top_entry),
    .below_i     (below_entry),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign status_o        = result.status;
  assign bracket_byte_o  = result.bracket_byte;
  assign line_number_o   = result.line;
  assign column_number_o = result.col;

endmodule

[bench/bracket_nesting_checker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_nesting_checker_top_tb
// Self-checking bench: feeds text streams and compares every bracket report.
// ----------------------------------------------------------------------------
// A queue of pending text words feeds a clocked driver, and a clocked monitor
// checks each report against a scoreboard filled by a cycle-free bracket
// tracker. The run covers a short directed set, full-depth nesting with an
// overflow, back-pressure and random well-formed and noisy text over a range
// of tab widths.
module bracket_nesting_checker_top_tb;
  import bnc_pkg::*;

  localparam int unsigned MAX_NEST     = MAX_NESTING_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STUCK_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned PHASE_WORDS  = 70;
  localparam logic [2:0]  TAB_WIDTH_ADDR = {REG_TAB_WIDTH, 2'b00};

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  bracket_byte_o;
  logic [23:0] line_number_o;
  logic [15:0] column_number_o;

  bracket_nesting_checker_top #(
    .MaxNesting(MAX_NEST)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .bracket_byte_o (bracket_byte_o),
    .line_number_o  (line_number_o),
    .column_number_o(column_number_o)
  );

  always #5 clk_i = ~clk_i;

  // Tracker state: a shadow of the checker's stack, position and flags.
  bnc_entry_t        nest_stack [MAX_NEST];
  int unsigned       nest_depth = 0;
  logic [LINE_W-1:0] cur_line = 1;
  logic [COL_W-1:0]  cur_col = 0;
  bit                nul_frozen = 0;
  bit                stream_failed = 0;
  logic [4:0]        tab_cols = TAB_WIDTH_RST;

  text_word_t  text_q [$];
  bnc_result_t pending_reports [$];
  text_word_t  next_word;
  bnc_result_t want;
  int unsigned fault_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned phase_words = 0;
  bit          tx_idle_on = 1;
  bit          rx_idle_on = 1;

  function automatic void add_report(status_e st, logic [7:0] bb, logic [LINE_W-1:0] ln,
                                     logic [COL_W-1:0] cl);
    bnc_result_t r;
    r.status       = st;
    r.bracket_byte = bb;
    r.line         = ln;
    r.col          = cl;
    pending_reports.push_back(r);
    stream_failed = 1;
  endfunction

  // Advances the shadow state by one accepted text word.
  function automatic void scan_byte(logic [7:0] b, logic last);
    logic [COL_W:0] col_sum;
    bnc_entry_t     top;
    col_sum = '0;
    if (!stream_failed) begin
      if (!nul_frozen) begin
        if (b == CHR_NUL) begin
          nul_frozen = 1;
        end else if (b == CHR_NL) begin
          if (cur_line != LINE_MAX) cur_line = cur_line + 1'b1;
          cur_col = '0;
        end else begin
          col_sum = {1'b0, cur_col} + ((b == CHR_TAB) ? {12'd0, tab_cols} : 17'd1);
          cur_col = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
        end
      end
      if (b == CHR_LPAREN || b == CHR_LBRACK) begin
        if (nest_depth >= MAX_NEST) begin
          add_report(ST_TOO_DEEP, b, cur_line, cur_col);
        end else begin
          nest_stack[nest_depth] = '{square: (b == CHR_LBRACK), line: cur_line, col: cur_col};
          nest_depth++;
        end
      end else if (b == CHR_RPAREN || b == CHR_RBRACK) begin
        if (nest_depth == 0) begin
          add_report(ST_UNMATCHED, b, cur_line, cur_col);
        end else begin
          nest_depth--;
          top = nest_stack[nest_depth];
          if (top.square != (b == CHR_RBRACK))
            add_report(ST_MISMATCH, top.square ? CHR_LBRACK : CHR_LPAREN, top.line, top.col);
        end
      end
      if (last && !stream_failed) begin
        if (nest_depth > 0) begin
          top = nest_stack[nest_depth-1];
          add_report(ST_UNCLOSED, top.square ? CHR_LBRACK : CHR_LPAREN, top.line, top.col);
        end else begin
          add_report(ST_OK, 8'h00, cur_line, cur_col);
        end
      end
    end
    if (last) begin
      nest_depth    = 0;
      cur_line      = 1;
      cur_col       = 0;
      nul_frozen    = 0;
      stream_failed = 0;
    end
  endfunction

  // Sender: one word in flight, an optional random gap after each accepted word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        scan_byte(text_byte_i, is_last_i);
        tx_gap = tx_idle_on ? $urandom_range(0, 17) : 0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (text_q.size() != 0) begin
          next_word = text_q.pop_front();
          text_byte_i <= next_word.text;
          is_last_i   <= next_word.last;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each report and stalls at random after it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("report with none pending: status %0d byte %02h line %0d column %0d",
                 status_o, bracket_byte_o, line_number_o, column_number_o);
          fault_count++;
        end else begin
          want = pending_reports.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fault_count++;
          end
          if (bracket_byte_o !== want.bracket_byte) begin
            $error("bracket_byte: expected %02h, got %02h", want.bracket_byte, bracket_byte_o);
            fault_count++;
          end
          if (line_number_o !== want.line) begin
            $error("line_number: expected %0d, got %0d", want.line, line_number_o);
            fault_count++;
          end
          if (column_number_o !== want.col) begin
            $error("column_number: expected %0d, got %0d", want.col, column_number_o);
            fault_count++;
          end
        end
        rx_stall = rx_idle_on ? $urandom_range(0, 17) : 0;
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("** bracket_nesting_checker_top: FAILED **");
      $finish;
    end
  end

  task automatic queue_word(input logic [7:0] b, input logic last);
    text_q.push_back('{text: b, last: last});
    phase_words++;
  endtask

  // Queues a string as one stream, the final character closing it.
  task automatic queue_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_word(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 11)) inside
      [0:3]:   return 8'h61 + 8'($urandom_range(0, 25));
      4:       return 8'h20;
      5, 6:    return CHR_NL;
      7:       return CHR_TAB;
      8:       return 8'($urandom_range(8'h80, 8'hFF));
      9:       return ($urandom_range(0, 7) == 0) ? CHR_NUL : 8'h2E;
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Mostly balanced text, with an occasional mismatch, stray closer or
  // opener left open.
  task automatic queue_nested_text(input int unsigned len);
    bit          kinds [$];
    logic [7:0]  body [$];
    bit          sq;
    int unsigned flaw;
    int unsigned pick;
    int          i;
    flaw = $urandom_range(0, 7);
    for (i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 && kinds.size() < 40) begin
        sq = $urandom_range(0, 1);
        kinds.push_back(sq);
        body.push_back(sq ? CHR_LBRACK : CHR_LPAREN);
      end else if (pick < 6 && kinds.size() != 0) begin
        sq = kinds.pop_back();
        if (flaw == 0 && $urandom_range(0, 5) == 0) sq = !sq;
        body.push_back(sq ? CHR_RBRACK : CHR_RPAREN);
      end else begin
        body.push_back(filler_byte());
      end
    end
    if (flaw == 1) body.push_back($urandom_range(0, 1) ? CHR_RBRACK : CHR_RPAREN);
    if (flaw != 2) begin
      while (kinds.size() != 0) body.push_back(kinds.pop_back() ? CHR_RBRACK : CHR_RPAREN);
    end
    if (body.size() == 0 || $urandom_range(0, 1)) body.push_back(filler_byte());
    for (i = 0; i < body.size(); i++) queue_word(body[i], i == body.size() - 1);
  endtask

  task automatic queue_noise_text(input int unsigned len);
    logic [7:0] b;
    int         i;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       b = CHR_LPAREN;
        1:       b = CHR_RPAREN;
        2:       b = CHR_LBRACK;
        3:       b = CHR_RBRACK;
        default: b = 8'($urandom_range(0, 255));
      endcase
      queue_word(b, i == len - 1);
    end
  endtask

  task automatic queue_random_phase();
    phase_words = 0;
    while (phase_words < PHASE_WORDS) begin
      if ($urandom_range(0, 4) == 0)
        queue_noise_text($urandom_range(1, 30));
      else if ($urandom_range(0, 9) == 0)
        queue_nested_text($urandom_range(40, 90));
      else
        queue_nested_text($urandom_range(0, 30));
    end
  endtask

  // Fills the stack to its full depth, then either overflows it or unwinds it.
  task automatic queue_full_depth(input bit overflow);
    bit kinds [$];
    bit sq;
    int i;
    for (i = 0; i < MAX_NEST; i++) begin
      sq = $urandom_range(0, 1);
      kinds.push_back(sq);
      queue_word(sq ? CHR_LBRACK : CHR_LPAREN, 1'b0);
    end
    if (overflow) begin
      queue_word($urandom_range(0, 1) ? CHR_LBRACK : CHR_LPAREN, 1'b0);
      queue_word(8'h78, 1'b0);
      queue_word(CHR_RPAREN, 1'b1);
    end else begin
      while (kinds.size() != 0) begin
        sq = kinds.pop_back();
        queue_word(sq ? CHR_RBRACK : CHR_RPAREN, kinds.size() == 0);
      end
    end
  endtask

  // Waits until every word is taken and every report has arrived, then lets
  // the checker finish any word that gives no report.
  task automatic wait_quiet();
    while (text_q.size() != 0 || in_valid_i || pending_reports.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic read_tab_width(output logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TAB_WIDTH_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_tab_width(input logic [4:0] cols);
    logic [31:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TAB_WIDTH_ADDR;
    pwdata  <= {27'd0, cols};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tab_cols = cols;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    read_tab_width(readback);
    if (readback[4:0] !== cols) begin
      $error("tab_width: expected %0d, got %0d", cols, readback[4:0]);
      fault_count++;
    end
  endtask

  initial begin
    logic [31:0] reset_tab;
    int          i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    read_tab_width(reset_tab);
    if (reset_tab[4:0] !== TAB_WIDTH_RST) begin
      $error("tab_width: expected %0d, got %0d", TAB_WIDTH_RST, reset_tab[4:0]);
      fault_count++;
    end

    // Directed streams at the reset tab width.
    queue_text("(\t[]\n)");
    queue_text(")");
    queue_text("(]xa");
    queue_text("[()\n");
    queue_word(8'h61, 1'b0);
    queue_word(CHR_NUL, 1'b0);
    queue_text("\n([)");
    queue_word(8'hFF, 1'b1);
    queue_text("]b(");
    wait_quiet();

    set_tab_width(5'd16);
    queue_full_depth(1'b1);
    queue_random_phase();
    wait_quiet();

    set_tab_width(5'd1);
    tx_idle_on = 0;
    queue_random_phase();
    wait_quiet();

    set_tab_width(5'd0);
    tx_idle_on = 1;
    rx_idle_on = 0;
    queue_random_phase();
    wait_quiet();

    // The widest tab value gives the largest column steps.
    set_tab_width(5'd31);
    rx_idle_on = 1;
    queue_random_phase();
    wait_quiet();

    // Hold the output for a long stretch while short reporting streams keep
    // arriving, so that the checker backs up and stalls its input.
    set_tab_width(5'($urandom_range(2, 15)));
    tx_idle_on = 0;
    rx_idle_on = 0;
    hold_requests++;
    for (i = 0; i < 80; i++) begin
      case ($urandom_range(0, 3))
        0:       queue_text(")");
        1:       queue_text("(");
        2:       queue_text("(]");
        default: queue_text("ab");
      endcase
    end
    wait_quiet();

    set_tab_width(5'($urandom_range(2, 15)));
    tx_idle_on = $urandom_range(0, 1);
    rx_idle_on = 1;
    queue_random_phase();
    wait_quiet();

    set_tab_width(TAB_WIDTH_RST);
    tx_idle_on = 1;
    queue_random_phase();
    wait_quiet();

    if (fault_count == 0)
      $display("** bracket_nesting_checker_top: PASSED **");
    else
      $display("** bracket_nesting_checker_top: FAILED **");
    $finish;
  end

endmodule

[bracket_nesting_checker_top.f]
hdl/bnc_pkg.sv
hdl/bnc_ram.sv
hdl/bnc_front.sv
hdl/bnc_back.sv
hdl/bracket_nesting_checker_top.sv
bench/bracket_nesting_checker_top_tb.sv
